// ===== hdl/dffp_pkg.sv =====
// Shared types, constants and helper functions of the delimited frame field parser.
package dffp_pkg;

  // Sequence registers hold up to four bytes each. Lengths are clamped to MAX_SEQ_BYTES.
  localparam int MAX_SEQ_BYTES = 4;
  localparam int SEQ_REG_BYTES = 4;
  localparam int SEQ_IDX_W     = $clog2(SEQ_REG_BYTES);
  localparam int CNT_W         = $clog2(MAX_SEQ_BYTES + 1);
  localparam int LEN_W         = 3;
  localparam int LEN_CMP_W     = 4;
  localparam int FCNT_W        = 4;

  // Payload store geometry.
  localparam int STORE_DEPTH = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int ENTRY_W     = 9;

  // Request queue between the parser and the drain engine.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes.
  localparam logic [2:0] REG_START_SEQ   = 3'd0;
  localparam logic [2:0] REG_START_LEN   = 3'd1;
  localparam logic [2:0] REG_SEP_SEQ     = 3'd2;
  localparam logic [2:0] REG_SEP_LEN     = 3'd3;
  localparam logic [2:0] REG_END_SEQ     = 3'd4;
  localparam logic [2:0] REG_END_LEN     = 3'd5;
  localparam logic [2:0] REG_FIELD_COUNT = 3'd6;

  // Queue request kinds.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Store entry with the field-end marker in the top bit.
  localparam logic [ENTRY_W-1:0] MARKER_ENTRY = {1'b1, 8'h00};

  typedef struct packed {
    logic [31:0]       start_seq;
    logic [LEN_W-1:0]  start_len;
    logic [31:0]       sep_seq;
    logic [LEN_W-1:0]  sep_len;
    logic [31:0]       end_seq;
    logic [LEN_W-1:0]  end_len;
    logic [FCNT_W-1:0] field_count;
  } cfg_t;

  // One request from the parser: a store write, or the end of a frame with its fill count.
  typedef struct packed {
    logic               op;
    logic [ENTRY_W-1:0] entry;
    logic [FILL_W-1:0]  idx;
  } q_entry_t;

  // Byte k of a sequence register; positions past the register read as zero.
  function automatic logic [7:0] seq_byte(input logic [31:0] seq, input logic [CNT_W-1:0] k);
    logic [7:0] b;
    b = 8'h00;
    if (k < CNT_W'(SEQ_REG_BYTES)) begin
      b = seq[{k[SEQ_IDX_W-1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Length clamped to the range from minimum to MAX_SEQ_BYTES.
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                               input logic [CNT_W-1:0] minimum);
    logic [LEN_CMP_W-1:0] v;
    v = LEN_CMP_W'(len);
    if (v < LEN_CMP_W'(minimum)) begin
      v = LEN_CMP_W'(minimum);
    end
    if (v > LEN_CMP_W'(MAX_SEQ_BYTES)) begin
      v = LEN_CMP_W'(MAX_SEQ_BYTES);
    end
    return CNT_W'(v);
  endfunction

endpackage

// ===== hdl/delimited_frame_field_parser.sv =====
// Top level of the delimited frame field parser: configuration registers and the two halves.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_rx_byte
//   out_     output     out_valid/out_stall out_payload_byte, out_has_byte, out_field_end,
//                                          out_frame_last
//   config   input      psel/penable/pwrite paddr, pwdata, prdata (pready tied high)
//
// The parser takes one byte per cycle while its four-entry request queue has room.
// A completed frame drains through the single store read port: each stored entry is
// read and then emitted, and the closing item follows the last entry.
// While a frame drains, requests pile up in the queue and the input stalls once it is full.
// Reset is synchronous and active low; the payload store is not cleared.
// A stall on the result side holds the output register and backs up into the queue.
module delimited_frame_field_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_payload_byte,
  output logic                        out_has_byte,
  output logic                        out_field_end,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dffp_pkg::ADDR_W-1:0] paddr,
  input  logic [dffp_pkg::DATA_W-1:0] pwdata,
  output logic [dffp_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dffp_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_we;
  logic [2:0] reg_idx;
  logic       push, q_full, q_not_empty, q_pop;
  q_entry_t   push_data, q_head;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_seq   <= 32'd0;
      cfg_r.start_len   <= LEN_W'(1);
      cfg_r.sep_seq     <= 32'd44;
      cfg_r.sep_len     <= LEN_W'(1);
      cfg_r.end_seq     <= 32'd10;
      cfg_r.end_len     <= LEN_W'(1);
      cfg_r.field_count <= FCNT_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_START_SEQ:   cfg_r.start_seq   <= pwdata;
        REG_START_LEN:   cfg_r.start_len   <= pwdata[LEN_W-1:0];
        REG_SEP_SEQ:     cfg_r.sep_seq     <= pwdata;
        REG_SEP_LEN:     cfg_r.sep_len     <= pwdata[LEN_W-1:0];
        REG_END_SEQ:     cfg_r.end_seq     <= pwdata;
        REG_END_LEN:     cfg_r.end_len     <= pwdata[LEN_W-1:0];
        REG_FIELD_COUNT: cfg_r.field_count <= pwdata[FCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_START_SEQ:   prdata = cfg_r.start_seq;
      REG_START_LEN:   prdata = DATA_W'(cfg_r.start_len);
      REG_SEP_SEQ:     prdata = cfg_r.sep_seq;
      REG_SEP_LEN:     prdata = DATA_W'(cfg_r.sep_len);
      REG_END_SEQ:     prdata = cfg_r.end_seq;
      REG_END_LEN:     prdata = DATA_W'(cfg_r.end_len);
      REG_FIELD_COUNT: prdata = DATA_W'(cfg_r.field_count);
      default:         prdata = '0;
    endcase
  end

  dffp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  dffp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dffp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_field_end    (out_field_end),
    .out_frame_last   (out_frame_last)
  );

endmodule

// ===== hdl/dffp_front.sv =====
// Front end: matches start, separator and end sequences and issues store requests.
module dffp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  dffp_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [7:0]          in_rx_byte,
  output logic                in_stall,
  input  logic                q_full,
  output logic                push,
  output dffp_pkg::q_entry_t  push_data
);
  import dffp_pkg::*;

  logic [CNT_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  sep_r, sep_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic [FCNT_W-1:0] fields_r, fields_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic [CNT_W-1:0]  sl, pl, el;
  logic [CNT_W-1:0]  sep_inc, end_inc;
  logic [FCNT_W-1:0] fields_inc;
  logic              accept;
  logic              store_full;
  logic              frame_clr;

  // The parser stalls only when the request queue has no room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign sl         = eff_len(cfg.start_len, CNT_W'(0));
  assign pl         = eff_len(cfg.sep_len, CNT_W'(1));
  assign el         = eff_len(cfg.end_len, CNT_W'(1));
  assign sep_inc    = sep_r + CNT_W'(1);
  assign end_inc    = end_r + CNT_W'(1);
  assign fields_inc = fields_r + FCNT_W'(1);
  assign store_full = fill_r >= FILL_W'(STORE_DEPTH);

  // Classify the accepted byte and work out the next match state.
  always_comb begin
    start_nxt       = start_r;
    sep_nxt         = sep_r;
    end_nxt         = end_r;
    fields_nxt      = fields_r;
    fill_nxt        = fill_r;
    frame_clr       = 1'b0;
    push            = 1'b0;
    push_data.op    = OP_WRITE;
    push_data.entry = {1'b0, in_rx_byte};
    push_data.idx   = fill_r;
    if (accept) begin
      priority if (start_r < sl && sep_r == '0 && end_r == '0 && fields_r == '0) begin
        // Matching the start sequence.
        if (in_rx_byte == seq_byte(cfg.start_seq, start_r)) begin
          start_nxt = start_r + CNT_W'(1);
        end else begin
          frame_clr = 1'b1;
        end
      end else if (start_r == sl && end_r == '0 && fields_r < cfg.field_count) begin
        // Collecting payload; separators win over the end sequence.
        priority if (sep_r < pl && in_rx_byte == seq_byte(cfg.sep_seq, sep_r)) begin
          if (sep_inc == pl) begin
            if (store_full) begin
              frame_clr = 1'b1;
            end else begin
              push            = 1'b1;
              push_data.entry = MARKER_ENTRY;
              fill_nxt        = fill_r + FILL_W'(1);
              fields_nxt      = fields_inc;
              sep_nxt         = '0;
            end
          end else begin
            sep_nxt = sep_inc;
          end
        end else if (sep_r != '0) begin
          frame_clr = 1'b1;
        end else if (in_rx_byte == seq_byte(cfg.end_seq, CNT_W'(0))) begin
          if (el == CNT_W'(1) && fields_inc == cfg.field_count) begin
            push         = 1'b1;
            push_data.op = OP_FINISH;
            frame_clr    = 1'b1;
          end else begin
            fields_nxt = fields_inc;
            end_nxt    = CNT_W'(1);
          end
        end else if (store_full) begin
          frame_clr = 1'b1;
        end else begin
          push     = 1'b1;
          fill_nxt = fill_r + FILL_W'(1);
        end
      end else if (start_r == sl && sep_r == '0 && end_r < el &&
                   fields_r == cfg.field_count) begin
        // Matching the rest of the end sequence.
        if (in_rx_byte == seq_byte(cfg.end_seq, end_r)) begin
          if (end_inc == el) begin
            push         = 1'b1;
            push_data.op = OP_FINISH;
            frame_clr    = 1'b1;
          end else begin
            end_nxt = end_inc;
          end
        end else begin
          frame_clr = 1'b1;
        end
      end else begin
        frame_clr = 1'b1;
      end
      // A drop or a completed frame returns the parser to its idle state.
      if (frame_clr) begin
        start_nxt  = '0;
        sep_nxt    = '0;
        end_nxt    = '0;
        fields_nxt = '0;
        fill_nxt   = '0;
      end
    end
  end

  // Match state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      sep_r    <= '0;
      end_r    <= '0;
      fields_r <= '0;
      fill_r   <= '0;
    end else begin
      start_r  <= start_nxt;
      sep_r    <= sep_nxt;
      end_r    <= end_nxt;
      fields_r <= fields_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== hdl/dffp_queue.sv =====
// Short request queue between the parser and the drain engine.
module dffp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dffp_pkg::q_entry_t  push_data,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output dffp_pkg::q_entry_t  head
);
  import dffp_pkg::*;

  q_entry_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push, do_pop;

  assign full      = count_r == Q_CNT_W'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/dffp_back.sv =====
// Back end: owns the payload store, performs writes and drains completed frames.
module dffp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  dffp_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_payload_byte,
  output logic                out_has_byte,
  output logic                out_field_end,
  output logic                out_frame_last
);
  import dffp_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;
  localparam logic [1:0] B_LAST = 2'd3;

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic [1:0]         state_r, state_nxt;
  logic [FILL_W-1:0]  cnt_r, cnt_nxt;
  logic [FILL_W-1:0]  len_r, len_nxt;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_has_r, out_fe_r, out_fl_r;
  logic               slot_free;
  logic               load_entry, load_last;
  logic               mem_we;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == B_IDLE) && q_not_empty;
  assign mem_we    = q_pop && (q_head.op == OP_WRITE);

  // Drain sequencer: each stored entry is read in B_READ, then emitted in B_EMIT.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    load_entry = 1'b0;
    load_last  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop && q_head.op == OP_FINISH) begin
          cnt_nxt   = '0;
          len_nxt   = q_head.idx;
          state_nxt = (q_head.idx == '0) ? B_LAST : B_READ;
        end
      end
      B_READ: begin
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free) begin
          load_entry = 1'b1;
          cnt_nxt    = cnt_r + FILL_W'(1);
          state_nxt  = (cnt_r + FILL_W'(1) == len_r) ? B_LAST : B_READ;
        end
      end
      B_LAST: begin
        if (slot_free) begin
          load_last = 1'b1;
          state_nxt = B_IDLE;
        end
      end
    endcase
  end

  // Payload store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.idx[IDX_W-1:0]] <= q_head.entry;
    end
    if (state_r == B_READ) begin
      rdata_r <= mem[cnt_r[IDX_W-1:0]];
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
    end
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_entry || load_last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_byte_r <= rdata_r[8] ? 8'h00 : rdata_r[7:0];
      out_has_r  <= !rdata_r[8];
      out_fe_r   <= rdata_r[8];
      out_fl_r   <= 1'b0;
    end else if (load_last) begin
      out_byte_r <= 8'h00;
      out_has_r  <= 1'b0;
      out_fe_r   <= 1'b1;
      out_fl_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_has_byte     = out_has_r;
  assign out_field_end    = out_fe_r;
  assign out_frame_last   = out_fl_r;

endmodule

// ===== hdl/dffp_checker.sv =====
// Port-level checker for the result channel of the parser, bound to the top level.
module dffp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_has_byte,
  input logic       out_field_end,
  input logic       out_frame_last
);

  // A stalled result request stays up and unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte) &&
      $stable(out_has_byte) && $stable(out_field_end) && $stable(out_frame_last))
    else $error("stalled result changed");

  // A result without a byte is a field end and carries a zero byte.
  a_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_field_end && out_payload_byte == 8'h00)
    else $error("bare result is not a clean field end");

  // A payload byte never closes a field or a frame.
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_byte |-> !out_field_end && !out_frame_last)
    else $error("payload byte flagged as field or frame end");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delimited_frame_field_parser dffp_checker u_dffp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_payload_byte (out_payload_byte),
  .out_has_byte     (out_has_byte),
  .out_field_end    (out_field_end),
  .out_frame_last   (out_frame_last)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the delimited frame field parser.
`timescale 1ns / 1ps

module testbench;
  import dffp_pkg::*;

  // One output request of the parser.
  typedef struct packed {
    logic [7:0] payload;
    logic       has_byte;
    logic       field_end;
    logic       frame_last;
  } frame_item_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // A row of the directed table: a byte to send or a register write.
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    bit          typed;
    int          n_typed;
    frame_item_t want [2];
  } stim_row_t;

  localparam frame_item_t CLOSE_ITEM = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam frame_item_t MARK_ITEM  = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_BYTES   = 45;
  localparam int MAX_REPORTS   = 10;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [7:0]          out_payload_byte;
  logic                out_has_byte;
  logic                out_field_end;
  logic                out_frame_last;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]   pwdata     = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Register copies that the predictor works from.
  logic [31:0] start_seq_r;
  logic [2:0]  start_len_r;
  logic [31:0] sep_seq_r;
  logic [2:0]  sep_len_r;
  logic [31:0] end_seq_r;
  logic [2:0]  end_len_r;
  logic [3:0]  field_count_r;

  // Parser state of the predictor.
  logic [2:0]  start_hits;
  logic [2:0]  sep_hits;
  logic [2:0]  end_hits;
  logic [3:0]  fields_closed;
  logic [8:0]  held_entries [STORE_DEPTH];
  logic [5:0]  held_count;

  frame_item_t burst [$];
  frame_item_t pending_items [$];
  stim_row_t   directed_rows [$];
  logic [7:0]  frame_bytes [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_go     = 1'b0;
  bit hold_rx     = 1'b0;
  int fail_count     = 0;
  int items_checked  = 0;
  int frames_checked = 0;
  int bytes_sent     = 0;
  int overflow_drops = 0;
  int input_stalls   = 0;
  int settings_used  = 0;

  delimited_frame_field_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_field_end    (out_field_end),
    .out_frame_last   (out_frame_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Byte k of a sequence register; positions past the register read as zero.
  function automatic logic [7:0] pick_byte(input logic [31:0] seq, input int k);
    if (k >= 4) begin
      return 8'h00;
    end
    return seq[8*k +: 8];
  endfunction

  function automatic int clamp_len(input logic [2:0] len, input int lowest);
    int v;
    v = int'(len);
    if (v < lowest) begin
      v = lowest;
    end
    if (v > MAX_SEQ_BYTES) begin
      v = MAX_SEQ_BYTES;
    end
    return v;
  endfunction

  function automatic void clear_frame();
    start_hits    = '0;
    sep_hits      = '0;
    end_hits      = '0;
    fields_closed = '0;
    held_count    = '0;
  endfunction

  // Returns 0 when the store is already full.
  function automatic bit hold_entry(input logic [8:0] entry);
    if (held_count >= STORE_DEPTH) begin
      return 1'b0;
    end
    held_entries[held_count[IDX_W-1:0]] = entry;
    held_count++;
    return 1'b1;
  endfunction

  // A completed frame: every stored entry in order, then the closing field end.
  function automatic void emit_stored();
    for (int i = 0; i < held_count; i++) begin
      if (held_entries[i][8]) begin
        burst.insert(burst.size(), MARK_ITEM);
      end else begin
        burst.insert(burst.size(), frame_item_t'{held_entries[i][7:0], 1'b1, 1'b0, 1'b0});
      end
    end
    burst.insert(burst.size(), CLOSE_ITEM);
    clear_frame();
  endfunction

  // Advances the parser by one received byte and leaves its output requests in burst.
  function automatic void parse_byte(input logic [7:0] b);
    int sl, pl, el, fc;
    sl = clamp_len(start_len_r, 0);
    pl = clamp_len(sep_len_r, 1);
    el = clamp_len(end_len_r, 1);
    fc = int'(field_count_r);
    burst.delete();
    if (start_hits < sl && sep_hits == 0 && end_hits == 0 && fields_closed == 0) begin
      // Hunting for the start sequence.
      if (b == pick_byte(start_seq_r, start_hits)) begin
        start_hits++;
      end else begin
        clear_frame();
      end
    end else if (start_hits == sl && end_hits == 0 && fields_closed < fc) begin
      // Payload: separator bytes take priority over the first end byte.
      if (sep_hits < pl && b == pick_byte(sep_seq_r, sep_hits)) begin
        sep_hits++;
        if (sep_hits == pl) begin
          if (!hold_entry({1'b1, 8'h00})) begin
            overflow_drops++;
            clear_frame();
          end else begin
            fields_closed++;
            sep_hits = '0;
          end
        end
      end else if (sep_hits != 0) begin
        clear_frame();
      end else if (b == pick_byte(end_seq_r, 0)) begin
        fields_closed++;
        end_hits = 3'd1;
        if (end_hits == el && fields_closed == fc) begin
          emit_stored();
        end
      end else if (!hold_entry({1'b0, b})) begin
        overflow_drops++;
        clear_frame();
      end
    end else if (start_hits == sl && sep_hits == 0 && end_hits < el && fields_closed == fc) begin
      // Count reached: only the rest of the end sequence may follow.
      if (b == pick_byte(end_seq_r, end_hits)) begin
        end_hits++;
        if (end_hits == el) begin
          emit_stored();
        end
      end else begin
        clear_frame();
      end
    end else begin
      clear_frame();
    end
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic [2:0] idx,
                                  input logic [31:0] value, input bit typed = 1'b0,
                                  input int n = 0, input frame_item_t w0 = '0,
                                  input frame_item_t w1 = '0);
    stim_row_t r;
    r.kind    = kind;
    r.reg_idx = idx;
    r.value   = value;
    r.typed   = typed;
    r.n_typed = n;
    r.want[0] = w0;
    r.want[1] = w1;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Sends one byte with random gaps ahead of it, then predicts what it causes.
  task automatic offer_byte(input logic [7:0] b, input bit predicted);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
    parse_byte(b);
    if (predicted) begin
      foreach (burst[i]) begin
        pending_items.insert(pending_items.size(), burst[i]);
      end
    end
  endtask

  // Waits until every expected output request has arrived and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_items.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START_SEQ:   start_seq_r   = value;
      REG_START_LEN:   start_len_r   = value[2:0];
      REG_SEP_SEQ:     sep_seq_r     = value;
      REG_SEP_LEN:     sep_len_r     = value[2:0];
      REG_END_SEQ:     end_seq_r     = value;
      REG_END_LEN:     end_len_r     = value[2:0];
      REG_FIELD_COUNT: field_count_r = value[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Flavor 0 is fully random, 1 uses the longest sequences and counts, 2 the shortest.
  task automatic random_config(input int flavor);
    settings_used++;
    write_reg(REG_START_SEQ, (flavor == 1) ? 32'hFFFF_FFFF : 32'($urandom));
    write_reg(REG_START_LEN, (flavor == 1) ? $urandom_range(4, 7) :
                             (flavor == 2) ? 0 : $urandom_range(0, 7));
    write_reg(REG_SEP_SEQ, $urandom);
    write_reg(REG_SEP_LEN, (flavor == 1) ? $urandom_range(4, 7) :
                           (flavor == 2) ? $urandom_range(0, 1) : $urandom_range(0, 7));
    write_reg(REG_END_SEQ, $urandom);
    write_reg(REG_END_LEN, (flavor == 1) ? $urandom_range(4, 7) :
                           (flavor == 2) ? $urandom_range(0, 1) : $urandom_range(0, 7));
    write_reg(REG_FIELD_COUNT, (flavor == 1) ? 15 :
                               (flavor == 2) ? $urandom_range(0, 1) :
                               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
  endtask

  // Payload byte that cannot be mistaken for a separator or end byte.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == pick_byte(sep_seq_r, 0) || b == pick_byte(end_seq_r, 0)) begin
      b = 8'($urandom);
    end
    return b;
  endfunction

  // Builds one frame under the current settings, or a burst of noise, or a damaged frame.
  task automatic build_frame();
    int sl, pl, el, fc, plen, pick;
    bit early;
    sl = clamp_len(start_len_r, 0);
    pl = clamp_len(sep_len_r, 1);
    el = clamp_len(end_len_r, 1);
    fc = int'(field_count_r);
    frame_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      return;
    end
    for (int k = 0; k < sl; k++) begin
      frame_bytes.insert(frame_bytes.size(), pick_byte(start_seq_r, k));
    end
    // Sometimes the separators alone reach the count and the last field stays empty.
    early = (fc > 0) && ($urandom_range(0, 4) == 0);
    for (int f = 0; f < fc; f++) begin
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 36) :
             $urandom_range(0, (fc > 6) ? 1 : 5);
      repeat (plen) frame_bytes.insert(frame_bytes.size(), plain_byte());
      if (f < fc - 1 || early) begin
        for (int k = 0; k < pl; k++) begin
          frame_bytes.insert(frame_bytes.size(), pick_byte(sep_seq_r, k));
        end
      end
    end
    for (int k = 0; k < el; k++) begin
      frame_bytes.insert(frame_bytes.size(), pick_byte(end_seq_r, k));
    end
    if (pick < 25) begin
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
    end
  endtask

  // Result side stalls at random, and for a long stretch when asked to.
  always @(posedge clk) begin
    out_stall <= hold_rx || ($urandom_range(0, 99) < rx_idle_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Compare each accepted output request with the oldest expectation.
  always @(posedge clk) begin
    frame_item_t got, want;
    if (in_valid && in_stall) begin
      input_stalls++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_payload_byte, out_has_byte, out_field_end, out_frame_last};
      if (pending_items.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected output: byte=%h has_byte=%b field_end=%b frame_last=%b",
                   got.payload, got.has_byte, got.field_end, got.frame_last);
        end
      end else begin
        want = pending_items.pop_front();
        items_checked++;
        if (got.payload !== want.payload || got.has_byte !== want.has_byte ||
            got.field_end !== want.field_end || got.frame_last !== want.frame_last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            // Fields in order: byte, has_byte, field_end, frame_last.
            $display("mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                     want.payload, want.has_byte, want.field_end, want.frame_last,
                     got.payload, got.has_byte, got.field_end, got.frame_last);
          end
        end else if (got.frame_last) begin
          frames_checked++;
        end
      end
    end
  end

  initial begin
    int phase_start;
    start_seq_r   = 32'd0;
    start_len_r   = 3'd1;
    sep_seq_r     = 32'd44;
    sep_len_r     = 3'd1;
    end_seq_r     = 32'd10;
    end_len_r     = 3'd1;
    field_count_r = 4'd1;
    clear_frame();

    // Directed table. Reset settings: start byte 00, separator ',', end '\n', one field.
    add_row(ROW_BYTE, '0, 8'h00);
    add_row(ROW_BYTE, '0, 8'h0A, 1'b1, 1, CLOSE_ITEM);
    add_row(ROW_BYTE, '0, 8'h00);
    add_row(ROW_BYTE, '0, 8'h41);
    add_row(ROW_BYTE, '0, 8'h0A, 1'b1, 2, frame_item_t'{8'h41, 1'b1, 1'b0, 1'b0}, CLOSE_ITEM);
    // The separator alone reaches the count, so the last field is empty.
    add_row(ROW_BYTE, '0, 8'h00);
    add_row(ROW_BYTE, '0, 8'h2C);
    add_row(ROW_BYTE, '0, 8'h0A, 1'b1, 2, MARK_ITEM, CLOSE_ITEM);
    // A wrong start byte is dropped.
    add_row(ROW_BYTE, '0, 8'h05, 1'b1, 0);
    // Two fields: an end byte before the count is reached drops the frame on the next byte.
    add_row(ROW_CFG, REG_FIELD_COUNT, 32'd2);
    add_row(ROW_BYTE, '0, 8'h00);
    add_row(ROW_BYTE, '0, 8'h41);
    add_row(ROW_BYTE, '0, 8'h0A);
    add_row(ROW_BYTE, '0, 8'h42, 1'b1, 0);
    add_row(ROW_BYTE, '0, 8'h00);
    add_row(ROW_BYTE, '0, 8'h41);
    add_row(ROW_BYTE, '0, 8'h2C);
    add_row(ROW_BYTE, '0, 8'h42);
    add_row(ROW_BYTE, '0, 8'h0A);
    // No start sequence, and a separator byte that equals the first end byte.
    add_row(ROW_CFG, REG_START_LEN, 32'd0);
    add_row(ROW_CFG, REG_SEP_SEQ, 32'h0000_000A);
    add_row(ROW_CFG, REG_END_SEQ, 32'h0000_FF0A);
    add_row(ROW_CFG, REG_END_LEN, 32'd2);
    add_row(ROW_CFG, REG_FIELD_COUNT, 32'd1);
    add_row(ROW_BYTE, '0, 8'h33);
    add_row(ROW_BYTE, '0, 8'h0A);
    add_row(ROW_BYTE, '0, 8'h0A);
    add_row(ROW_BYTE, '0, 8'hFF);
    // Zero field count with clamped lengths: the end byte right after the start closes
    // one empty field.
    add_row(ROW_CFG, REG_FIELD_COUNT, 32'd0);
    add_row(ROW_CFG, REG_START_LEN, 32'd7);
    add_row(ROW_CFG, REG_START_SEQ, 32'hFFFF_FFFF);
    add_row(ROW_CFG, REG_SEP_LEN, 32'd7);
    add_row(ROW_CFG, REG_SEP_SEQ, 32'h0403_0201);
    add_row(ROW_CFG, REG_END_LEN, 32'd0);
    add_row(ROW_CFG, REG_END_SEQ, 32'h0000_00FF);
    repeat (4) add_row(ROW_BYTE, '0, 8'hFF);
    add_row(ROW_BYTE, '0, 8'hFF, 1'b1, 1, CLOSE_ITEM);

    // Reset is held low before the run begins.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, without idling.
    settings_used = 4;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        offer_byte(directed_rows[i].value[7:0], !directed_rows[i].typed);
        for (int k = 0; k < directed_rows[i].n_typed; k++) begin
          pending_items.insert(pending_items.size(), directed_rows[i].want[k]);
        end
      end
    end

    // Random frames: the sender idles less than the receiver first, then the other way
    // round, then neither idles.
    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = (m == 0) ? 37 : (m == 1) ? 79 : 0;
      rx_idle_pct <= (m == 0) ? 79 : (m == 1) ? 37 : 0;
      for (int p = 0; p < 3; p++) begin
        settle();
        random_config(p);
        // Short frames with a long receiver hold-off fill the block up.
        if (m == 2 && p == 2) begin
          hold_go <= 1'b1;
        end
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES) begin
          build_frame();
          foreach (frame_bytes[i]) begin
            offer_byte(frame_bytes[i], 1'b1);
          end
        end
      end
    end

    settle();
    $display("summary: %0d bytes, %0d register settings, %0d requests in %0d frames checked",
             bytes_sent, settings_used, items_checked, frames_checked);
    $display("summary: %0d overflow drops, %0d cycles of input stall, %0d mismatches",
             overflow_drops, input_stalls, fail_count);
    if (fail_count == 0 && pending_items.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
